// ----- hw/rtl/kprwo_pkg.sv -----
// shared types, constants and colour function for the keyed plate recolour block
`timescale 1ns / 1ps
`default_nettype none

package kprwo_pkg;

    // default frame limits
    localparam int MAX_WIDTH_DEF  = 32;
    localparam int MAX_HEIGHT_DEF = 32;

    // register file port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int SIZE_W     = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_DARK_PANEL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_THR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RED_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE_LIMIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_W     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_H     = 3'd6;

    // register reset values
    localparam logic [7:0]        RST_ALPHA_THR   = 8'd40;
    localparam logic [7:0]        RST_RED_LIMIT   = 8'd48;
    localparam logic [7:0]        RST_GREEN_LIMIT = 8'd52;
    localparam logic [7:0]        RST_BLUE_LIMIT  = 8'd72;
    localparam logic [SIZE_W-1:0] RST_FRAME_W     = 6'd24;
    localparam logic [SIZE_W-1:0] RST_FRAME_H     = 6'd24;

    // colour sets
    localparam logic [7:0] LIGHT_PLATE_R = 8'd232;
    localparam logic [7:0] LIGHT_PLATE_G = 8'd236;
    localparam logic [7:0] LIGHT_PLATE_B = 8'd241;
    localparam logic [7:0] LIGHT_RING_R  = 8'd255;
    localparam logic [7:0] LIGHT_RING_G  = 8'd255;
    localparam logic [7:0] LIGHT_RING_B  = 8'd255;
    localparam logic [7:0] DARK_PLATE_R  = 8'd18;
    localparam logic [7:0] DARK_PLATE_G  = 8'd26;
    localparam logic [7:0] DARK_PLATE_B  = 8'd42;
    localparam logic [7:0] DARK_RING_R   = 8'd20;
    localparam logic [7:0] DARK_RING_G   = 8'd24;
    localparam logic [7:0] DARK_RING_B   = 8'd36;

    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
    localparam logic [7:0] ALPHA_CLEAR  = 8'd0;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // one stored pixel: colour plus binarised opacity
    typedef struct packed {
        logic opq;
        t_rgb rgb;
    } t_pix;

    // line store entry: pixel of the row above plus opacity of the row above that
    typedef struct packed {
        logic up_opq;
        t_pix pix;
    } t_entry;

    // one column of the 3x3 neighbourhood
    typedef struct packed {
        logic top_opq;
        t_pix mid;
        logic bot_opq;
    } t_col;

    function automatic t_rgb f_recolor(t_pix p, logic ring, logic dark,
                                       logic [7:0] rlim, logic [7:0] glim,
                                       logic [7:0] blim);
        t_rgb c;
        c = p.rgb;
        if (p.opq && (p.rgb.red < rlim) && (p.rgb.green < glim) && (p.rgb.blue < blim)) begin
            if (ring) begin
                c.red   = dark ? LIGHT_RING_R : DARK_RING_R;
                c.green = dark ? LIGHT_RING_G : DARK_RING_G;
                c.blue  = dark ? LIGHT_RING_B : DARK_RING_B;
            end else begin
                c.red   = dark ? LIGHT_PLATE_R : DARK_PLATE_R;
                c.green = dark ? LIGHT_PLATE_G : DARK_PLATE_G;
                c.blue  = dark ? LIGHT_PLATE_B : DARK_PLATE_B;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/keyed_plate_recolor_with_outline.sv -----
// keyed plate recolour with outline: line-store based pixel stream processor
`timescale 1ns / 1ps
`default_nettype none

// channel     dir  handshake                      content
// s_axis      in   s_axis_tvalid / s_axis_tready  pixel red, green, blue, alpha
// m_axis      out  m_axis_tvalid / m_axis_tready  processed pixel, frame end, last of burst
// cfg         in   i_cfg_valid / o_cfg_ready      register index and write data
//
// one pixel item per cycle inside a row while m_axis does not stall; the last column
//   of rows after the first holds the input for two results, the second from a tail state
// the last pixel of a frame holds the input through the flush, which reads one column
//   per cycle while m_axis does not stall, through the single line store read port
// results leave through one output register, so stalls on m_axis hold the pipeline
// reset clears counters and control; the line store holds no reset value and needs
//   no clearing pass, as entries read in the first row only feed masked terms
// config writes are taken at any time, one per cycle

module keyed_plate_recolor_with_outline #(
    parameter int MAX_WIDTH  = kprwo_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = kprwo_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // pixel in, tdata: red[7:0], green[15:8], blue[23:16], alpha[31:24]
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [31:0]                      s_axis_tdata,
    // pixel out, tdata: out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24]
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic [31:0]                           m_axis_tdata,
    output logic                                  m_axis_tlast,  // burst_last
    output logic                                  m_axis_tuser,  // frame_end
    // register writes
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [kprwo_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [kprwo_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import kprwo_pkg::*;

    // column address width, effective height limit and row counter width
    localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CNT_W = AW + 1;
    localparam int HEFF  = (MAX_HEIGHT < 63) ? MAX_HEIGHT : 63;
    localparam int RW    = (HEFF > 1) ? $clog2(HEFF) : 1;

    typedef enum logic [2:0] {
        S_RUN   = 3'b001,   // normal streaming
        S_TAIL  = 3'b010,   // second result at the end of a row
        S_FLUSH = 3'b100    // last row read back and sent out
    } t_state;

    // item held between line store read and write back
    typedef struct packed {
        logic [AW-1:0] x;
        logic          r_ge1;
        logic          r_ge2;
        logic          last_col;
        logic          last_row;
        t_pix          pix;
    } t_s1;

    // configuration registers
    logic              r_dark;
    logic [7:0]        r_athr;
    logic [7:0]        r_rlim;
    logic [7:0]        r_glim;
    logic [7:0]        r_blim;
    logic [SIZE_W-1:0] r_fwid;
    logic [SIZE_W-1:0] r_fhgt;

    // control state
    t_state         r_state, n_state;
    logic [AW-1:0]  r_col;
    logic [RW-1:0]  r_row;
    logic           r_s1_valid, n_s1_valid;
    t_s1            r_s1;
    logic           r_m_valid;
    logic [CNT_W-1:0] r_fl_cnt;
    logic           r_fd_valid;
    logic [AW-1:0]  r_fd_idx;

    // line store and its read data register
    t_entry         r_mem [MAX_WIDTH];
    t_entry         r_rd;

    // neighbourhood columns x-1 and x-2
    t_col           r_w1, r_w2;

    // output register
    logic [31:0]    r_m_data;
    logic           r_m_last;
    logic           r_m_user;

    // combinational
    logic [SIZE_W-1:0] w_eff, h_eff;
    logic           in_acc, out_free;
    logic           restart;
    logic [AW-1:0]  x_in;
    logic [RW-1:0]  row_in;
    logic           lc_in, lr_in;
    t_s1            s1_in;
    logic           emit_a, fire, more, win_shift;
    logic           mem_we, rd_en;
    logic [AW-1:0]  rd_addr;
    t_entry         wd;
    t_col           cur_col;
    logic           interior;
    logic           res_valid, res_ring, res_last, res_fend;
    t_pix           res_pix;
    t_rgb           res_rgb;
    logic           fl_issue, fl_emit, fl_last, fl_enter;

    // frame size, out-of-range values clamped
    always_comb begin
        if (r_fwid == '0) begin
            w_eff = SIZE_W'(1);
        end else if (int'(r_fwid) > MAX_WIDTH) begin
            w_eff = SIZE_W'(MAX_WIDTH);
        end else begin
            w_eff = r_fwid;
        end
        if (r_fhgt == '0) begin
            h_eff = SIZE_W'(1);
        end else if (int'(r_fhgt) > HEFF) begin
            h_eff = SIZE_W'(HEFF);
        end else begin
            h_eff = r_fhgt;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign in_acc      = s_axis_tvalid && s_axis_tready;
    assign out_free    = !r_m_valid || m_axis_tready;

    // position of the incoming pixel; a shrunk frame restarts at the origin
    always_comb begin
        restart = (SIZE_W'(r_col) >= w_eff) || (SIZE_W'(r_row) >= h_eff);
        x_in    = restart ? '0 : r_col;
        row_in  = restart ? '0 : r_row;
        lc_in   = (SIZE_W'(x_in) + SIZE_W'(1)) == w_eff;
        lr_in   = (SIZE_W'(row_in) + SIZE_W'(1)) == h_eff;
        s1_in.x        = x_in;
        s1_in.r_ge1    = row_in != '0;
        s1_in.r_ge2    = row_in > RW'(1);
        s1_in.last_col = lc_in;
        s1_in.last_row = lr_in;
        s1_in.pix.opq  = s_axis_tdata[31:24] >= r_athr;
        s1_in.pix.rgb.red   = s_axis_tdata[7:0];
        s1_in.pix.rgb.green = s_axis_tdata[15:8];
        s1_in.pix.rgb.blue  = s_axis_tdata[23:16];
    end

    // column x of the neighbourhood: row r-2 opacity, row r-1 pixel, row r opacity
    always_comb begin
        cur_col.top_opq = r_rd.up_opq;
        cur_col.mid     = r_rd.pix;
        cur_col.bot_opq = r_s1.pix.opq;
        // pixel x-1 sits inside when it has rows above and below and columns both sides
        interior = r_s1.r_ge2 && (r_s1.x > AW'(1))
                && r_w2.top_opq && r_w1.top_opq && cur_col.top_opq
                && r_w2.bot_opq && r_w1.bot_opq && cur_col.bot_opq
                && r_w2.mid.opq && cur_col.mid.opq;
        // write back: this row's pixel, and the opacity of the row now above
        wd.up_opq = r_rd.pix.opq;
        wd.pix    = r_s1.pix;
    end

    // sequencing of results
    always_comb begin
        n_state    = r_state;
        n_s1_valid = r_s1_valid;
        emit_a     = r_s1_valid && r_s1.r_ge1 && (r_s1.x != '0);
        fire       = 1'b0;
        more       = r_s1.last_col && (r_s1.r_ge1 || r_s1.last_row);
        win_shift  = 1'b0;
        mem_we     = 1'b0;
        res_valid  = 1'b0;
        res_ring   = 1'b1;
        res_last   = 1'b0;
        res_fend   = 1'b0;
        res_pix    = r_w1.mid;
        fl_issue   = 1'b0;
        fl_emit    = 1'b0;
        fl_last    = 1'b0;
        fl_enter   = 1'b0;
        s_axis_tready = 1'b0;

        unique case (r_state)
            S_RUN: begin
                fire = r_s1_valid && (!emit_a || out_free);
                s_axis_tready = !r_s1_valid || (fire && !more);
                if (fire) begin
                    mem_we    = 1'b1;
                    win_shift = 1'b1;
                    res_valid = emit_a;
                    res_ring  = !interior;
                    res_last  = !r_s1.last_col;
                    if (r_s1.last_col && r_s1.r_ge1) begin
                        n_state = S_TAIL;
                    end else if (r_s1.last_col && r_s1.last_row) begin
                        n_state  = S_FLUSH;
                        fl_enter = 1'b1;
                    end else begin
                        n_s1_valid = 1'b0;
                    end
                end
                if (s_axis_tvalid && s_axis_tready) begin
                    n_s1_valid = 1'b1;
                end
            end
            S_TAIL: begin
                // last column: always on the border
                if (out_free) begin
                    res_valid = 1'b1;
                    res_last  = !r_s1.last_row;
                    if (r_s1.last_row) begin
                        n_state  = S_FLUSH;
                        fl_enter = 1'b1;
                    end else begin
                        n_state    = S_RUN;
                        n_s1_valid = 1'b0;
                    end
                end
            end
            S_FLUSH: begin
                // last row has nothing below it, so every keyed pixel gets the ring
                fl_issue = (SIZE_W'(r_fl_cnt) < w_eff) && (!r_fd_valid || out_free);
                fl_emit  = r_fd_valid && out_free;
                fl_last  = (SIZE_W'(r_fd_idx) + SIZE_W'(1)) == w_eff;
                if (fl_emit) begin
                    res_valid = 1'b1;
                    res_pix   = r_rd.pix;
                    res_last  = fl_last;
                    res_fend  = fl_last;
                    if (fl_last) begin
                        n_state    = S_RUN;
                        n_s1_valid = 1'b0;
                    end
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase

        rd_en   = (s_axis_tvalid && s_axis_tready) || fl_issue;
        rd_addr = (r_state == S_FLUSH) ? r_fl_cnt[AW-1:0] : x_in;
        res_rgb = f_recolor(res_pix, res_ring, r_dark, r_rlim, r_glim, r_blim);
    end

    // line store: one write and one read per cycle, write data forwarded on a clash
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_s1.x] <= wd;
        end
        if (rd_en) begin
            if (mem_we && (r_s1.x == rd_addr)) begin
                r_rd <= wd;
            end else begin
                r_rd <= r_mem[rd_addr];
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dark     <= 1'b0;
            r_athr     <= RST_ALPHA_THR;
            r_rlim     <= RST_RED_LIMIT;
            r_glim     <= RST_GREEN_LIMIT;
            r_blim     <= RST_BLUE_LIMIT;
            r_fwid     <= RST_FRAME_W;
            r_fhgt     <= RST_FRAME_H;
            r_state    <= S_RUN;
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
            r_m_valid  <= 1'b0;
            r_fl_cnt   <= '0;
            r_fd_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_DARK_PANEL:  r_dark <= i_cfg_data[0];
                    CFG_ALPHA_THR:   r_athr <= i_cfg_data;
                    CFG_RED_LIMIT:   r_rlim <= i_cfg_data;
                    CFG_GREEN_LIMIT: r_glim <= i_cfg_data;
                    CFG_BLUE_LIMIT:  r_blim <= i_cfg_data;
                    CFG_FRAME_W:     r_fwid <= i_cfg_data[SIZE_W-1:0];
                    CFG_FRAME_H:     r_fhgt <= i_cfg_data[SIZE_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (in_acc) begin
                if (lc_in) begin
                    r_col <= '0;
                    r_row <= lr_in ? '0 : row_in + RW'(1);
                end else begin
                    r_col <= x_in + AW'(1);
                    r_row <= row_in;
                end
            end
            r_state    <= n_state;
            r_s1_valid <= n_s1_valid;
            if (res_valid) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            if (fl_enter) begin
                r_fl_cnt   <= '0;
                r_fd_valid <= 1'b0;
            end else begin
                if (fl_issue) begin
                    r_fl_cnt <= r_fl_cnt + CNT_W'(1);
                end
                if (fl_issue) begin
                    r_fd_valid <= 1'b1;
                end else if (fl_emit) begin
                    r_fd_valid <= 1'b0;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= s1_in;
        end
        if (win_shift) begin
            r_w2 <= r_w1;
            r_w1 <= cur_col;
        end
        if (fl_issue) begin
            r_fd_idx <= r_fl_cnt[AW-1:0];
        end
        if (res_valid) begin
            r_m_data <= {res_pix.opq ? ALPHA_OPAQUE : ALPHA_CLEAR,
                         res_rgb.blue, res_rgb.green, res_rgb.red};
            r_m_last <= res_last;
            r_m_user <= res_fend;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;
    assign m_axis_tuser  = r_m_user;

    // frame end only ever closes a burst
    a_fend_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("frame end without burst end");

    // tail and flush only run on behalf of a held item
    a_state_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAIL || r_state == S_FLUSH) |-> r_s1_valid)
        else $error("tail or flush without held item");

    // forwarding on a same-entry read and write
    a_forward: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(rd_en && mem_we && (r_s1.x == rd_addr)) |-> (r_rd == $past(wd)))
        else $error("line store forwarding lost");

    // flush never reads beyond the row
    a_flush_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH) |-> (SIZE_W'(r_fl_cnt) <= w_eff))
        else $error("flush read beyond row");

endmodule

`default_nettype wire

// ----- test/recolor_checker.sv -----
// predicts and checks the output pixel stream of the keyed plate recolour block
`timescale 1ns / 1ps

module recolor_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    input  logic                             i_s_tready,
    input  logic [31:0]                      i_s_tdata,
    input  logic                             i_m_tvalid,
    input  logic                             i_m_tready,
    input  logic [31:0]                      i_m_tdata,
    input  logic                             i_m_tlast,
    input  logic                             i_m_tuser,
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_ready,
    input  logic [kprwo_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [kprwo_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                               o_errors,
    output int                               o_waiting,
    output int                               o_checked
);
    import kprwo_pkg::*;

    localparam int MAXW = MAX_WIDTH_DEF;
    localparam int MAXH = MAX_HEIGHT_DEF;

    typedef struct packed {
        t_rgb       rgb;
        logic [7:0] alpha;
        logic       frame_end;
        logic       burst_last;
    } t_out_px;

    // register copy
    logic       dark;
    logic [7:0] thr, rlim, glim, blim;
    logic [5:0] fw, fh;

    // frame position and line stores
    int   col, row;
    logic older_opq [MAXW];
    t_pix pend      [MAXW];
    t_pix cur       [MAXW];

    t_out_px due_pixels [$];
    t_out_px want;

    // pending pixel x leaves the block
    task automatic release_pending(input int x, input int w, input bit up, input bit down,
                                   input bit fend, input bit blast);
        t_out_px o;
        t_pix    p;
        bit      ring;
        p = pend[x];
        o.rgb        = p.rgb;
        o.alpha      = p.opq ? ALPHA_OPAQUE : ALPHA_CLEAR;
        o.frame_end  = fend;
        o.burst_last = blast;
        if (p.opq && p.rgb.red < rlim && p.rgb.green < glim && p.rgb.blue < blim) begin
            ring = !up || !down || x == 0 || x + 1 >= w;
            for (int c = x - 1; c <= x + 1 && !ring; c++) begin
                if (!older_opq[c] || !cur[c].opq || (c != x && !pend[c].opq))
                    ring = 1'b1;
            end
            if (ring)
                o.rgb = dark ? {LIGHT_RING_R, LIGHT_RING_G, LIGHT_RING_B}
                             : {DARK_RING_R, DARK_RING_G, DARK_RING_B};
            else
                o.rgb = dark ? {LIGHT_PLATE_R, LIGHT_PLATE_G, LIGHT_PLATE_B}
                             : {DARK_PLATE_R, DARK_PLATE_G, DARK_PLATE_B};
        end
        due_pixels.push_back(o);
    endtask

    task automatic absorb_pixel(input logic [31:0] d);
        int   w, h, x, r;
        bit   last_col, last_row;
        t_pix p;
        w = (fw == 0) ? 1 : (fw > MAXW) ? MAXW : int'(fw);
        h = (fh == 0) ? 1 : (fh > MAXH) ? MAXH : int'(fh);
        // frame shrunk under the counters: start over
        if (col >= w || row >= h) begin
            col = 0;
            row = 0;
        end
        x = col;
        r = row;
        p.rgb = {d[7:0], d[15:8], d[23:16]};
        p.opq = (d[31:24] >= thr);
        cur[x] = p;
        last_col = (x + 1 == w);
        last_row = (r + 1 == h);
        if (r >= 1) begin
            if (x >= 1)
                release_pending(x - 1, w, r >= 2, 1'b1, 1'b0, !last_col);
            if (last_col)
                release_pending(x, w, r >= 2, 1'b1, 1'b0, !last_row);
        end
        if (last_col) begin
            for (int i = 0; i < w; i++) begin
                older_opq[i] = pend[i].opq;
                pend[i]      = cur[i];
            end
            if (last_row) begin
                for (int i = 0; i < w; i++)
                    release_pending(i, w, r >= 1, 1'b0, i == w - 1, i == w - 1);
                row = 0;
            end else begin
                row = r + 1;
            end
            col = 0;
        end else begin
            col = x + 1;
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v, input logic [7:0] got);
        if (got !== exp_v) begin
            o_errors++;
            $display("%0t: result %0d %s expected %0d got %0d", $time, o_checked, name, exp_v, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dark = 1'b0;
            thr  = RST_ALPHA_THR;
            rlim = RST_RED_LIMIT;
            glim = RST_GREEN_LIMIT;
            blim = RST_BLUE_LIMIT;
            fw   = RST_FRAME_W;
            fh   = RST_FRAME_H;
            col  = 0;
            row  = 0;
            due_pixels.delete();
            o_errors  = 0;
            o_checked = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DARK_PANEL:  dark = i_cfg_data[0];
                    CFG_ALPHA_THR:   thr  = i_cfg_data;
                    CFG_RED_LIMIT:   rlim = i_cfg_data;
                    CFG_GREEN_LIMIT: glim = i_cfg_data;
                    CFG_BLUE_LIMIT:  blim = i_cfg_data;
                    CFG_FRAME_W:     fw   = i_cfg_data[5:0];
                    CFG_FRAME_H:     fh   = i_cfg_data[5:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                absorb_pixel(i_s_tdata);
            if (i_m_tvalid && i_m_tready) begin
                if (due_pixels.size() == 0) begin
                    o_errors++;
                    $display("%0t: result with none expected, tdata %h tlast %b tuser %b",
                             $time, i_m_tdata, i_m_tlast, i_m_tuser);
                end else begin
                    want = due_pixels.pop_front();
                    check_field("out_red", want.rgb.red, i_m_tdata[7:0]);
                    check_field("out_green", want.rgb.green, i_m_tdata[15:8]);
                    check_field("out_blue", want.rgb.blue, i_m_tdata[23:16]);
                    check_field("out_alpha", want.alpha, i_m_tdata[31:24]);
                    check_field("frame_end", {7'd0, want.frame_end}, {7'd0, i_m_tuser});
                    check_field("burst_last", {7'd0, want.burst_last}, {7'd0, i_m_tlast});
                    o_checked++;
                end
            end
        end
        o_waiting = due_pixels.size();
    end

endmodule

// ----- test/tb.sv -----
// testbench top for the keyed plate recolour block: stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb;
    import kprwo_pkg::*;

    // cycles with no item moving on any channel before the run is called hung;
    // the longest honest gap is a short settle pause or a run of random stalls
    localparam int QUIET_LIMIT   = 2000;
    // pause after the last expected result before touching registers
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_PIXELS = 190;

    typedef enum int {
        FLOW_FREE,
        FLOW_SRC_GAPS,
        FLOW_SINK_STALLS,
        FLOW_BOTH
    } t_flow;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // pixel in: red[7:0], green[15:8], blue[23:16], alpha[31:24]
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_data  = '0;
    // pixel out: same packing; tlast is burst_last, tuser is frame_end
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_data;
    logic        m_last;
    logic        m_user;
    // register writes
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_DARK_PANEL;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int errors, waiting, checked;

    // register values the stimulus currently works with
    logic       dark;
    logic [7:0] thr, rlim, glim, blim;
    logic [5:0] fw, fh;

    t_flow flow = FLOW_FREE;
    int    pixels_in   = 0;
    int    frames_sent = 0;
    int    reg_writes  = 0;
    int    quiet_cycles = 0;
    int    random_start;
    int    phase;

    // 4x4 frame for the directed part, packed {alpha, blue, green, red}
    logic [31:0] key_pattern [16] = '{
        32'hFF00_0000,  // opaque black, corner: ring
        32'hFFFF_FFFF,  // opaque white, never keyed
        32'h2847_332F,  // alpha right at threshold, colour one under every limit
        32'hFF00_0030,  // red right at its limit: kept
        32'hFF0A_0A0A,  // keyed on the left edge: ring
        32'hFF00_0000,  // interior, all eight neighbours opaque: plate
        32'hFF00_0000,  // interior next to a clear pixel below right: ring
        32'hFF00_3300,  // green one under its limit, right edge
        32'hFF48_0000,  // blue right at its limit: kept
        32'hFF00_0000,  // interior with a clear pixel below left: ring
        32'hC803_0201,  // mid alpha, keyed
        32'h2700_0000,  // alpha one under threshold: transparent
        32'h0000_0000,  // fully clear bottom row start
        32'hFF00_0000,  // bottom row keyed: ring
        32'hFF00_0000,
        32'h00FF_FFFF   // clear white closes the frame
    };

    keyed_plate_recolor_with_outline u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tlast  (m_last),
        .m_axis_tuser  (m_user),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    recolor_checker u_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_valid),
        .i_s_tready  (s_ready),
        .i_s_tdata   (s_data),
        .i_m_tvalid  (m_valid),
        .i_m_tready  (m_ready),
        .i_m_tdata   (m_data),
        .i_m_tlast   (m_last),
        .i_m_tuser   (m_user),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_waiting   (waiting),
        .o_checked   (checked)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // receiver side back-pressure, changed on the falling edge
    always @(negedge clk) begin
        case (flow)
            FLOW_SINK_STALLS: m_ready <= ($urandom_range(0, 99) >= 54);
            FLOW_BOTH:        m_ready <= ($urandom_range(0, 99) >= 9);
            default:          m_ready <= 1'b1;
        endcase
    end

    // watchdog: counts cycles in which nothing is handed over anywhere
    always @(posedge clk) begin
        if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: nothing moved for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, waiting);
            $display("tb failed");
            $finish;
        end
    end

    // colour channel mostly under its limit, alpha mostly at or over threshold,
    // with the boundary values and plain noise mixed in
    function automatic logic [7:0] pick_level(input logic [7:0] lim, input bit at_or_above);
        int k;
        k = $urandom_range(0, 99);
        if (k < 15)
            return 8'($urandom_range(255, 0));
        if (k < 30)
            return (k < 22) ? lim : lim - 8'd1;
        if (at_or_above)
            return 8'($urandom_range(255, lim));
        if (lim == 8'd0)
            return 8'($urandom_range(255, 0));
        return 8'($urandom_range(lim - 1, 0));
    endfunction

    function automatic logic [31:0] make_pixel();
        return {pick_level(thr, 1'b1), pick_level(blim, 1'b0),
                pick_level(glim, 1'b0), pick_level(rlim, 1'b0)};
    endfunction

    // threshold or limit value, the extremes often
    function automatic logic [7:0] pick_reg();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(255, 0));
        endcase
    endfunction

    // called on a falling edge, returns on the falling edge after the item is taken
    task automatic send_pixel(input logic [31:0] d);
        while ((flow == FLOW_SRC_GAPS && $urandom_range(0, 99) < 54) ||
               (flow == FLOW_BOTH && $urandom_range(0, 99) < 9)) begin
            s_valid <= 1'b0;
            @(negedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= d;
        @(posedge clk);
        while (!s_ready)
            @(posedge clk);
        @(negedge clk);
        pixels_in++;
    endtask

    task automatic send_frames(input int frames);
        int w, h;
        w = (fw == 0) ? 1 : (fw > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(fw);
        h = (fh == 0) ? 1 : (fh > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : int'(fh);
        repeat (frames * w * h)
            send_pixel(make_pixel());
        frames_sent += frames;
    endtask

    // stop sending, wait for every expected result, then let the block drain a little more
    task automatic settle(input int cycles);
        s_valid <= 1'b0;
        while (waiting != 0)
            @(negedge clk);
        repeat (cycles) @(negedge clk);
    endtask

    // only ever done with the block idle
    task automatic reconfigure();
        logic [CFG_IDX_W-1:0] order [7];
        order = '{CFG_DARK_PANEL, CFG_ALPHA_THR, CFG_RED_LIMIT, CFG_GREEN_LIMIT,
                  CFG_BLUE_LIMIT, CFG_FRAME_W, CFG_FRAME_H};
        settle(SETTLE_CYCLES);
        foreach (order[i]) begin
            cfg_valid <= 1'b1;
            cfg_index <= order[i];
            case (order[i])
                CFG_DARK_PANEL:  cfg_data <= {7'd0, dark};
                CFG_ALPHA_THR:   cfg_data <= thr;
                CFG_RED_LIMIT:   cfg_data <= rlim;
                CFG_GREEN_LIMIT: cfg_data <= glim;
                CFG_BLUE_LIMIT:  cfg_data <= blim;
                CFG_FRAME_W:     cfg_data <= {2'b00, fw};
                default:         cfg_data <= {2'b00, fh};
            endcase
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            @(negedge clk);
            reg_writes++;
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: the hand-made 4x4 frame with the default colour set and limits
        dark = 1'b0;
        thr  = RST_ALPHA_THR;
        rlim = RST_RED_LIMIT;
        glim = RST_GREEN_LIMIT;
        blim = RST_BLUE_LIMIT;
        fw   = 6'd4;
        fh   = 6'd4;
        reconfigure();
        foreach (key_pattern[i])
            send_pixel(key_pattern[i]);
        frames_sent++;

        // directed: light colour set, stop a 3x3 frame in its last row, then
        // shrink the height under the row counter so the block starts over
        dark = 1'b1;
        fw   = 6'd3;
        fh   = 6'd3;
        reconfigure();
        repeat (7) send_pixel(make_pixel());
        fh = 6'd2;
        reconfigure();
        send_frames(1);

        // random phases, each on a frame boundary
        random_start = pixels_in;
        phase = 0;
        while (pixels_in - random_start < RANDOM_PIXELS) begin
            flow = t_flow'((phase + 2) % 4);
            dark = 1'($urandom_range(1, 0));
            thr  = pick_reg();
            rlim = pick_reg();
            glim = pick_reg();
            blim = pick_reg();
            fw   = 6'($urandom_range(8, 1));
            fh   = 6'($urandom_range(6, 1));
            case (phase)
                // width over the maximum, two rows: the longest burst at frame end
                0: begin
                    fw  = 6'd63;
                    fh  = 6'd2;
                    thr = 8'd0;
                end
                // width zero acts as one column, height over the maximum
                1: begin
                    fw = 6'd0;
                    fh = 6'd40;
                end
                // height zero acts as a single row
                2: fh = 6'd0;
                default: ;
            endcase
            reconfigure();
            send_frames((phase < 2) ? 1 : $urandom_range(3, 1));
            phase++;
        end

        settle(4 * SETTLE_CYCLES);
        $display("run: %0d pixels in, %0d results checked, %0d frames, %0d register writes",
                 pixels_in, checked, frames_sent, reg_writes);
        $display("run: both colour sets, clamped sizes, mid-frame restart, four flow patterns");
        if (errors == 0 && waiting == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// ----- keyed_plate_recolor_with_outline.f -----
hw/rtl/kprwo_pkg.sv
hw/rtl/keyed_plate_recolor_with_outline.sv
test/recolor_checker.sv
test/tb.sv
